// ===== rtl/core/running_mode_value_tracker_assert.svh =====
// Assertion helpers for the mode tracker.
// RMVT_ASSERT checks a property on the rising clock edge, off while reset is held.
// RMVT_ASSERT_NEVER checks that a condition is never true.
`ifndef RUNNING_MODE_VALUE_TRACKER_ASSERT_SVH
`define RUNNING_MODE_VALUE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define RMVT_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) \
	else $error("rmvt assertion failed");
`define RMVT_ASSERT_NEVER(lbl, ck, rstn, cond) \
	`RMVT_ASSERT(lbl, ck, rstn, !(cond))
`else
`define RMVT_ASSERT(lbl, ck, rstn, prop)
`define RMVT_ASSERT_NEVER(lbl, ck, rstn, cond)
`endif
`endif

// ===== rtl/core/rmvt_pkg.sv =====
package rmvt_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 16;
	localparam int USED_W  = 5;
	localparam int OUT_W   = 56;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// order_mode codes
	localparam logic ORDER_DESC = 1'b0;
	localparam logic ORDER_ASC  = 1'b1;

	// what a cell hands to its right neighbor
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_W-1:0]        count;
	} cell_link_t;

	// per-cell status toward the top level
	typedef struct packed {
		logic               hit;
		logic               ins_pos;
		logic [COUNT_W-1:0] hit_count;
	} cell_stat_t;

endpackage

// ===== rtl/core/rmvt_cell.sv =====
module rmvt_cell
	import rmvt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic                      restart,
	input  logic                      insert,
	input  logic                      order_mode,
	input  logic signed [VALUE_W-1:0] sample,
	input  cell_link_t                left,
	input  logic                      seen_in,
	output logic                      seen_out,
	output cell_link_t                link,
	output cell_stat_t                stat
);

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      eff_valid;
	logic                      goes_before;
	logic                      stop;
	logic [COUNT_W-1:0]        inc_count;

	always_comb begin
		eff_valid   = valid_q & ~restart;
		goes_before = (order_mode == ORDER_ASC) ? (value_q < sample) : (value_q > sample);
		// first cell that is empty or does not precede the sample takes it
		stop        = ~eff_valid | ~goes_before;
		seen_out    = seen_in | stop;
		inc_count   = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
		stat.hit       = eff_valid & (value_q == sample);
		stat.ins_pos   = stop & ~seen_in;
		stat.hit_count = stat.hit ? inc_count : '0;
		link.valid  = eff_valid;
		link.value  = value_q;
		link.count  = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			if (insert && stat.ins_pos) begin
				valid_q <= 1'b1;
			end else if (insert && seen_in) begin
				valid_q <= left.valid;
			end else begin
				valid_q <= eff_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (insert && stat.ins_pos) begin
				value_q <= sample;
				count_q <= COUNT_W'(1);
			end else if (insert && seen_in) begin
				value_q <= left.value;
				count_q <= left.count;
			end else if (stat.hit) begin
				count_q <= inc_count;
			end
		end
	end

endmodule

// ===== rtl/core/running_mode_value_tracker.sv =====
// Running mode tracker: counts occurrences of signed 32-bit values and reports
// the most frequent one after every item.
// Input channel s_*: s_tdata carries sample_value, s_tuser carries restart,
// which empties the table before that item's value is counted.
// Output channel m_*: one result item per input item, with the mode value,
// its saturating count, the number of distinct entries and a dropped flag.
// Config: cfg_we/cfg_wdata write order_mode (0 descending, 1 ascending);
// write only while no item is in flight.
// Output: the result of an item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle while the receiver drains results; the whole
// row of cells compares, shifts and updates in the cycle the item is accepted,
// and the best entry is tracked incrementally so no scan over the table is needed.
// Stall: the result sits in the output register; s_tready is high while that
// register is empty or being drained, so a stalled receiver holds off input.
// Reset: table empty, order_mode descending, no result pending. Reset is
// asynchronous, active low.
module running_mode_value_tracker
	import rmvt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] sample_value
	input  logic             s_tuser,   // [0] restart
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [31:0] mode_value, [47:32] mode_count,
	                                    // [52:48] entries_used, [55:53] zero
	output logic             m_tuser,   // [0] dropped
	input  logic             cfg_we,
	input  logic             cfg_wdata  // order_mode
);

	`include "running_mode_value_tracker_assert.svh"

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW = $clog2(TABLE_DEPTH + 1);

	logic                      order_mode_q;
	logic                      take;
	logic signed [VALUE_W-1:0] sample;
	logic                      restart;

	cell_link_t                link [TABLE_DEPTH+1];
	cell_stat_t                stat [TABLE_DEPTH];
	logic [TABLE_DEPTH:0]      seen;
	logic [TABLE_DEPTH-1:0]    hit_vec;
	logic [TABLE_DEPTH-1:0]    pos_vec;

	logic                      found;
	logic                      full;
	logic                      insert;
	logic                      dropped;
	logic [COUNT_W-1:0]        hit_count;
	logic [IW-1:0]             hit_idx;
	logic [IW-1:0]             pos_idx;

	logic signed [VALUE_W-1:0] best_val_q, best_val_d;
	logic [COUNT_W-1:0]        best_cnt_q, best_cnt_d, eff_cnt;
	logic [IW-1:0]             bidx_q, bidx_d;
	logic [UW-1:0]             used_q, used_d;
	logic [UW+USED_W-1:0]      used_ext;

	logic                      out_valid_q;
	logic [OUT_W-1:0]          out_data_q;
	logic                      out_drop_q;

	assign sample   = s_tdata;
	assign restart  = s_tuser;
	assign s_tready = ~out_valid_q | m_tready;
	assign take     = s_tvalid & s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= ORDER_DESC;
		end else if (cfg_we) begin
			order_mode_q <= cfg_wdata;
		end
	end

	// row of cells; the insert point ripples left to right through seen[]
	assign link[0] = '0;
	assign seen[0] = 1'b0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		rmvt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.take       (take),
			.restart    (restart),
			.insert     (insert),
			.order_mode (order_mode_q),
			.sample     (sample),
			.left       (link[g]),
			.seen_in    (seen[g]),
			.seen_out   (seen[g+1]),
			.link       (link[g+1]),
			.stat       (stat[g])
		);
		assign hit_vec[g] = stat[g].hit;
		assign pos_vec[g] = stat[g].ins_pos;
	end

	always_comb begin
		hit_count = '0;
		hit_idx   = '0;
		pos_idx   = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_count = hit_count | stat[i].hit_count;
			if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
			if (pos_vec[i]) pos_idx = pos_idx | IW'(i);
		end
	end

	assign found   = |hit_vec;
	assign full    = link[TABLE_DEPTH].valid;
	assign insert  = ~found & ~full;
	assign dropped = ~found & full;
	assign eff_cnt = restart ? '0 : best_cnt_q;

	// incremental best: lowest-index entry with the highest count
	always_comb begin
		best_val_d = best_val_q;
		best_cnt_d = eff_cnt;
		bidx_d     = bidx_q;
		if (found) begin
			if ((hit_count > eff_cnt) || ((hit_count == eff_cnt) && (hit_idx <= bidx_q))) begin
				best_val_d = sample;
				best_cnt_d = hit_count;
				bidx_d     = hit_idx;
			end
		end else if (insert) begin
			if ((eff_cnt == '0) || ((eff_cnt == COUNT_W'(1)) && (pos_idx <= bidx_q))) begin
				best_val_d = sample;
				best_cnt_d = COUNT_W'(1);
				bidx_d     = pos_idx;
			end else if (pos_idx <= bidx_q) begin
				// best entry moves one place right
				bidx_d = bidx_q + IW'(1);
			end
		end
		used_d   = (restart ? '0 : used_q) + UW'(insert);
		used_ext = {{USED_W{1'b0}}, used_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_cnt_q  <= '0;
			bidx_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				best_cnt_q <= best_cnt_d;
				bidx_q     <= bidx_d;
				used_q     <= used_d;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_val_q <= best_val_d;
			out_data_q <= {3'b000, used_ext[USED_W-1:0], best_cnt_d, best_val_d};
			out_drop_q <= dropped;
		end
	end

	`RMVT_ASSERT(a_hit_onehot0, clk, arst_n, $onehot0(hit_vec))
	`RMVT_ASSERT(a_pos_onehot0, clk, arst_n, $onehot0(pos_vec))
	`RMVT_ASSERT(a_insert_has_pos, clk, arst_n, (take && insert) |-> $onehot(pos_vec))
	`RMVT_ASSERT(a_best_in_table, clk, arst_n, (used_q != '0) |-> (UW'(bidx_q) < used_q))
	`RMVT_ASSERT_NEVER(a_best_cnt_empty, clk, arst_n, (used_q != '0) && (best_cnt_q == '0))

endmodule
